// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the PNG checker RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property checked every clock outside reset
`define PNGC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Antecedent in one cycle implies consequent in the next
`define PNGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PNGC_ASSERT(lbl, clk, rst_n, prop)
`define PNGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/pngc_pkg.sv =====
// Shared types, codes, constant tables and the CRC-32 byte step.
// No dependencies; used by the parser, the result queue and the top level.
package pngc_pkg;

    // Parser phases
    typedef enum logic [3:0] {
        PH_SIG       = 4'd0,
        PH_IHDR_LEN  = 4'd1,
        PH_IHDR_TYPE = 4'd2,
        PH_IHDR_DATA = 4'd3,
        PH_IHDR_CRC  = 4'd4,
        PH_CH_LEN    = 4'd5,
        PH_CH_TYPE   = 4'd6,
        PH_SKIP_DATA = 4'd7,
        PH_SKIP_CRC  = 4'd8,
        PH_IDAT_DATA = 4'd9,
        PH_IDAT_CRC  = 4'd10
    } t_phase;

    // Verdict codes
    typedef enum logic [3:0] {
        ST_RGBA_OK     = 4'd0,
        ST_RGB_OK      = 4'd1,
        ST_SIGNATURE   = 4'd2,
        ST_IHDR_TYPE   = 4'd3,
        ST_IHDR_LEN    = 4'd4,
        ST_IHDR_CRC    = 4'd5,
        ST_SIZE        = 4'd6,
        ST_DEPTH       = 4'd7,
        ST_COMPRESSION = 4'd8,
        ST_FILTER      = 4'd9,
        ST_INTERLACE   = 4'd10,
        ST_COLOR_TYPE  = 4'd11,
        ST_TRUNCATED   = 4'd12,
        ST_IDAT_CRC    = 4'd13
    } t_status;

    // Configuration register indexes
    localparam logic CFG_MAX_WIDTH  = 1'b0;
    localparam logic CFG_MAX_HEIGHT = 1'b1;

    localparam logic [30:0] MAX_DIM_RESET = 31'd8192;
    localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
    localparam logic [31:0] IHDR_LENGTH   = 32'd13;
    localparam logic [7:0]  BIT_DEPTH_8   = 8'd8;
    localparam logic [7:0]  COLOR_RGB     = 8'd2;
    localparam logic [7:0]  COLOR_RGBA    = 8'd6;

    // Result queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // One verdict record
    typedef struct packed {
        t_status     status;
        logic [30:0] image_width;
        logic [30:0] image_height;
        logic [7:0]  color_kind;
        logic [31:0] idat_length;
    } t_result;

    // File signature bytes
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h89;
            3'd1:    v = 8'h50;
            3'd2:    v = 8'h4E;
            3'd3:    v = 8'h47;
            3'd4:    v = 8'h0D;
            3'd5:    v = 8'h0A;
            3'd6:    v = 8'h1A;
            default: v = 8'h0A;
        endcase
        return v;
    endfunction

    // "IHDR"
    function automatic logic [7:0] ihdr_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'h49;
            2'd1:    v = 8'h48;
            2'd2:    v = 8'h44;
            default: v = 8'h52;
        endcase
        return v;
    endfunction

    // "IDAT"
    function automatic logic [7:0] idat_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'h49;
            2'd1:    v = 8'h44;
            2'd2:    v = 8'h41;
            default: v = 8'h54;
        endcase
        return v;
    endfunction

    // Reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/pngc_parser.sv =====
// Front end: byte-wise PNG signature / IHDR / IDAT parser with running CRC-32.
// Depends on pngc_pkg and assert_macros.svh; emits verdict records to the queue.
`include "assert_macros.svh"

module pngc_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_index,
    input  logic [30:0]        i_cfg_wr_data,
    output logic               o_push,
    output pngc_pkg::t_result  o_result
);

    // Limits
    logic [30:0] r_max_width;
    logic [30:0] r_max_height;

    // Parse state
    pngc_pkg::t_phase r_phase, n_phase, phase_step;
    logic [31:0] r_byte_count, n_byte_count, s_byte_count;
    logic [31:0] r_crc, n_crc, s_crc;
    logic [31:0] r_chunk_len, n_chunk_len, s_chunk_len;
    logic        r_type_match, n_type_match, s_type_match;
    logic [31:0] r_stored_crc, n_stored_crc, s_stored_crc;
    logic [31:0] r_width, n_width, s_width;
    logic [31:0] r_height, n_height, s_height;
    logic [39:0] r_hdr, n_hdr, s_hdr;
    logic        r_verdict_given, n_verdict_given;

    // Byte classification
    logic [31:0] cnt_inc;
    logic [31:0] crc_step;
    logic [31:0] shift_stored;
    logic        sig_ok, ihdr_ok, idat_ok;
    logic        cnt4;
    logic        active;

    // Verdict decision
    logic              verdict_valid;
    pngc_pkg::t_status verdict_code;
    logic              go_chunks;
    logic              parsed, in_idat;
    logic              size_bad;

    assign active       = i_valid && !r_verdict_given;
    assign cnt_inc      = r_byte_count + 32'd1;
    assign cnt4         = (cnt_inc == 32'd4);
    assign crc_step     = pngc_pkg::crc_byte(r_crc, i_data_byte);
    assign shift_stored = {r_stored_crc[23:0], i_data_byte};
    assign sig_ok       = (i_data_byte == pngc_pkg::sig_byte(r_byte_count[2:0]));
    assign ihdr_ok      = (i_data_byte == pngc_pkg::ihdr_byte(r_byte_count[1:0]));
    assign idat_ok      = (i_data_byte == pngc_pkg::idat_byte(r_byte_count[1:0]));
    assign size_bad     = (r_width == 32'd0) || (r_height == 32'd0) ||
                          (r_width > {1'b0, r_max_width}) ||
                          (r_height > {1'b0, r_max_height});

    // Verdict outputs of the phase machine
    always_comb begin
        verdict_valid = 1'b0;
        verdict_code  = pngc_pkg::ST_RGBA_OK;
        go_chunks     = 1'b0;
        unique case (r_phase)
            pngc_pkg::PH_SIG: begin
                if (cnt_inc == 32'd8 && !(r_type_match && sig_ok)) begin
                    verdict_valid = 1'b1;
                    verdict_code  = pngc_pkg::ST_SIGNATURE;
                end
            end
            pngc_pkg::PH_IHDR_TYPE: begin
                if (cnt4) begin
                    if (!(r_type_match && ihdr_ok)) begin
                        verdict_valid = 1'b1;
                        verdict_code  = pngc_pkg::ST_IHDR_TYPE;
                    end else if (r_chunk_len != pngc_pkg::IHDR_LENGTH) begin
                        verdict_valid = 1'b1;
                        verdict_code  = pngc_pkg::ST_IHDR_LEN;
                    end
                end
            end
            pngc_pkg::PH_IHDR_CRC: begin
                if (cnt4) begin
                    verdict_valid = 1'b1;
                    if (~r_crc != shift_stored) begin
                        verdict_code = pngc_pkg::ST_IHDR_CRC;
                    end else if (size_bad) begin
                        verdict_code = pngc_pkg::ST_SIZE;
                    end else if (r_hdr[39:32] != pngc_pkg::BIT_DEPTH_8) begin
                        verdict_code = pngc_pkg::ST_DEPTH;
                    end else if (r_hdr[23:16] != 8'd0) begin
                        verdict_code = pngc_pkg::ST_COMPRESSION;
                    end else if (r_hdr[15:8] != 8'd0) begin
                        verdict_code = pngc_pkg::ST_FILTER;
                    end else if (r_hdr[7:0] != 8'd0) begin
                        verdict_code = pngc_pkg::ST_INTERLACE;
                    end else if (r_hdr[31:24] == pngc_pkg::COLOR_RGB) begin
                        verdict_code = pngc_pkg::ST_RGB_OK;
                    end else if (r_hdr[31:24] == pngc_pkg::COLOR_RGBA) begin
                        verdict_valid = 1'b0;
                        go_chunks     = 1'b1;
                    end else begin
                        verdict_code = pngc_pkg::ST_COLOR_TYPE;
                    end
                end
            end
            pngc_pkg::PH_IDAT_CRC: begin
                if (cnt4) begin
                    verdict_valid = 1'b1;
                    verdict_code  = (~r_crc == shift_stored) ? pngc_pkg::ST_RGBA_OK
                                                             : pngc_pkg::ST_IDAT_CRC;
                end
            end
            default: begin
            end
        endcase
    end

    // Next phase
    always_comb begin
        phase_step = r_phase;
        unique case (r_phase)
            pngc_pkg::PH_SIG: begin
                if (cnt_inc == 32'd8 && r_type_match && sig_ok)
                    phase_step = pngc_pkg::PH_IHDR_LEN;
            end
            pngc_pkg::PH_IHDR_LEN: begin
                if (cnt4) phase_step = pngc_pkg::PH_IHDR_TYPE;
            end
            pngc_pkg::PH_CH_LEN: begin
                if (cnt4) phase_step = pngc_pkg::PH_CH_TYPE;
            end
            pngc_pkg::PH_IHDR_TYPE: begin
                if (cnt4 && r_type_match && ihdr_ok &&
                    r_chunk_len == pngc_pkg::IHDR_LENGTH)
                    phase_step = pngc_pkg::PH_IHDR_DATA;
            end
            pngc_pkg::PH_IHDR_DATA: begin
                if (cnt_inc == 32'd13) phase_step = pngc_pkg::PH_IHDR_CRC;
            end
            pngc_pkg::PH_IHDR_CRC: begin
                if (go_chunks) phase_step = pngc_pkg::PH_CH_LEN;
            end
            pngc_pkg::PH_CH_TYPE: begin
                if (cnt4) begin
                    if (r_type_match && idat_ok)
                        phase_step = (r_chunk_len == 32'd0) ? pngc_pkg::PH_IDAT_CRC
                                                            : pngc_pkg::PH_IDAT_DATA;
                    else
                        phase_step = (r_chunk_len == 32'd0) ? pngc_pkg::PH_SKIP_CRC
                                                            : pngc_pkg::PH_SKIP_DATA;
                end
            end
            pngc_pkg::PH_SKIP_DATA: begin
                if (cnt_inc == r_chunk_len) phase_step = pngc_pkg::PH_SKIP_CRC;
            end
            pngc_pkg::PH_SKIP_CRC: begin
                if (cnt4) phase_step = pngc_pkg::PH_CH_LEN;
            end
            pngc_pkg::PH_IDAT_DATA: begin
                if (cnt_inc == r_chunk_len) phase_step = pngc_pkg::PH_IDAT_CRC;
            end
            pngc_pkg::PH_IDAT_CRC: begin
            end
            default: begin
            end
        endcase
        if (r_verdict_given) phase_step = r_phase;
        n_phase = i_last_byte ? pngc_pkg::PH_SIG : phase_step;
    end

    // Datapath updates
    always_comb begin
        s_byte_count = r_byte_count;
        s_crc        = r_crc;
        s_chunk_len  = r_chunk_len;
        s_type_match = r_type_match;
        s_stored_crc = r_stored_crc;
        s_width      = r_width;
        s_height     = r_height;
        s_hdr        = r_hdr;
        case (r_phase) inside
            pngc_pkg::PH_SIG: begin
                s_type_match = r_type_match & sig_ok;
                s_byte_count = (cnt_inc == 32'd8 && s_type_match) ? 32'd0 : cnt_inc;
            end
            pngc_pkg::PH_IHDR_LEN, pngc_pkg::PH_CH_LEN: begin
                s_chunk_len = {r_chunk_len[23:0], i_data_byte};
                if (cnt4) begin
                    s_byte_count = 32'd0;
                    s_crc        = pngc_pkg::CRC_INIT;
                    s_type_match = 1'b1;
                end else begin
                    s_byte_count = cnt_inc;
                end
            end
            pngc_pkg::PH_IHDR_TYPE: begin
                s_crc        = crc_step;
                s_type_match = r_type_match & ihdr_ok;
                s_byte_count = (cnt4 && s_type_match &&
                                r_chunk_len == pngc_pkg::IHDR_LENGTH) ? 32'd0 : cnt_inc;
            end
            pngc_pkg::PH_IHDR_DATA: begin
                s_crc = crc_step;
                if (r_byte_count < 32'd4)
                    s_width = {r_width[23:0], i_data_byte};
                else if (r_byte_count < 32'd8)
                    s_height = {r_height[23:0], i_data_byte};
                else
                    s_hdr = {r_hdr[31:0], i_data_byte};
                if (cnt_inc == 32'd13) begin
                    s_byte_count = 32'd0;
                    s_stored_crc = 32'd0;
                end else begin
                    s_byte_count = cnt_inc;
                end
            end
            pngc_pkg::PH_IHDR_CRC: begin
                s_stored_crc = shift_stored;
                s_byte_count = go_chunks ? 32'd0 : cnt_inc;
            end
            pngc_pkg::PH_CH_TYPE: begin
                s_crc        = crc_step;
                s_type_match = r_type_match & idat_ok;
                if (cnt4) begin
                    s_byte_count = 32'd0;
                    s_stored_crc = 32'd0;
                end else begin
                    s_byte_count = cnt_inc;
                end
            end
            pngc_pkg::PH_SKIP_DATA: begin
                s_byte_count = (cnt_inc == r_chunk_len) ? 32'd0 : cnt_inc;
            end
            pngc_pkg::PH_SKIP_CRC: begin
                if (cnt4) begin
                    s_byte_count = 32'd0;
                    s_chunk_len  = 32'd0;
                end else begin
                    s_byte_count = cnt_inc;
                end
            end
            pngc_pkg::PH_IDAT_DATA: begin
                s_crc        = crc_step;
                s_byte_count = (cnt_inc == r_chunk_len) ? 32'd0 : cnt_inc;
            end
            pngc_pkg::PH_IDAT_CRC: begin
                s_stored_crc = shift_stored;
                s_byte_count = cnt_inc;
            end
            default: begin
            end
        endcase

        // After a verdict the bytes are dropped
        if (r_verdict_given) begin
            s_byte_count = r_byte_count;
            s_crc        = r_crc;
            s_chunk_len  = r_chunk_len;
            s_type_match = r_type_match;
            s_stored_crc = r_stored_crc;
            s_width      = r_width;
            s_height     = r_height;
            s_hdr        = r_hdr;
        end

        // End of file restarts the parser
        if (i_last_byte) begin
            n_byte_count    = 32'd0;
            n_crc           = pngc_pkg::CRC_INIT;
            n_chunk_len     = 32'd0;
            n_type_match    = 1'b1;
            n_stored_crc    = 32'd0;
            n_width         = 32'd0;
            n_height        = 32'd0;
            n_hdr           = 40'd0;
            n_verdict_given = 1'b0;
        end else begin
            n_byte_count    = s_byte_count;
            n_crc           = s_crc;
            n_chunk_len     = s_chunk_len;
            n_type_match    = s_type_match;
            n_stored_crc    = s_stored_crc;
            n_width         = s_width;
            n_height        = s_height;
            n_hdr           = s_hdr;
            n_verdict_given = r_verdict_given | verdict_valid;
        end
    end

    // Result record, fields as they stand after this byte
    assign parsed  = (phase_step != pngc_pkg::PH_SIG) &&
                     (phase_step != pngc_pkg::PH_IHDR_LEN) &&
                     (phase_step != pngc_pkg::PH_IHDR_TYPE) &&
                     (phase_step != pngc_pkg::PH_IHDR_DATA);
    assign in_idat = (phase_step == pngc_pkg::PH_IDAT_DATA) ||
                     (phase_step == pngc_pkg::PH_IDAT_CRC);

    assign o_push                = active && (verdict_valid || i_last_byte);
    assign o_result.status       = verdict_valid ? verdict_code : pngc_pkg::ST_TRUNCATED;
    assign o_result.image_width  = parsed ? s_width[30:0] : 31'd0;
    assign o_result.image_height = parsed ? s_height[30:0] : 31'd0;
    assign o_result.color_kind   = parsed ? s_hdr[31:24] : 8'd0;
    assign o_result.idat_length  = in_idat ? s_chunk_len : 32'd0;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_width  <= pngc_pkg::MAX_DIM_RESET;
            r_max_height <= pngc_pkg::MAX_DIM_RESET;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == pngc_pkg::CFG_MAX_WIDTH)  r_max_width  <= i_cfg_wr_data;
            if (i_cfg_index == pngc_pkg::CFG_MAX_HEIGHT) r_max_height <= i_cfg_wr_data;
        end
    end

    // Parse state registers, advanced on each byte transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= pngc_pkg::PH_SIG;
            r_byte_count    <= 32'd0;
            r_crc           <= pngc_pkg::CRC_INIT;
            r_chunk_len     <= 32'd0;
            r_type_match    <= 1'b1;
            r_stored_crc    <= 32'd0;
            r_width         <= 32'd0;
            r_height        <= 32'd0;
            r_hdr           <= 40'd0;
            r_verdict_given <= 1'b0;
        end else if (i_valid) begin
            r_phase         <= n_phase;
            r_byte_count    <= n_byte_count;
            r_crc           <= n_crc;
            r_chunk_len     <= n_chunk_len;
            r_type_match    <= n_type_match;
            r_stored_crc    <= n_stored_crc;
            r_width         <= n_width;
            r_height        <= n_height;
            r_hdr           <= n_hdr;
            r_verdict_given <= n_verdict_given;
        end
    end

    // Checks; a failed signature parks the count at eight until the file ends
    `PNGC_ASSERT(a_silent_after_verdict, i_clk, i_rst_n, (r_verdict_given && i_valid) |-> !o_push)
    `PNGC_ASSERT(a_sig_count_range, i_clk, i_rst_n,
        (r_phase == pngc_pkg::PH_SIG && !r_verdict_given) |-> (r_byte_count < 32'd8))
    `PNGC_ASSERT(a_rgba_from_idat, i_clk, i_rst_n,
        (o_push && o_result.status == pngc_pkg::ST_RGBA_OK) |-> (r_phase == pngc_pkg::PH_IDAT_CRC))
    `PNGC_ASSERT_NEXT(a_restart, i_clk, i_rst_n, (i_valid && i_last_byte),
        (r_phase == pngc_pkg::PH_SIG && !r_verdict_given))

endmodule

// ===== rtl/core/pngc_fifo.sv =====
// Back end: small verdict queue between the parser and the result port.
// Depends on pngc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pngc_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  pngc_pkg::t_result  i_data,
    input  logic               i_rd,
    output pngc_pkg::t_result  o_head,
    output logic               o_empty,
    output logic               o_full
);

    pngc_pkg::t_result r_mem [pngc_pkg::QDEPTH];

    logic [pngc_pkg::QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [pngc_pkg::QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [pngc_pkg::QPTR_W:0]   r_count, n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (pngc_pkg::QPTR_W+1)'(pngc_pkg::QDEPTH));
    assign o_head  = r_mem[r_rd_ptr];

    // Pointer and count updates
    always_comb begin
        n_wr_ptr = i_wr ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_rd ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_wr && !i_rd) n_count = r_count + 1'b1;
        if (!i_wr && i_rd) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wr_ptr] <= i_data;
    end

    // Checks
    `PNGC_ASSERT(a_no_write_when_full, i_clk, i_rst_n, !(i_wr && o_full && !i_rd))
    `PNGC_ASSERT(a_no_read_when_empty, i_clk, i_rst_n, !(i_rd && o_empty))
    `PNGC_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, (i_wr && !i_rd), (r_count == $past(r_count) + 1'b1))

endmodule

// ===== rtl/core/png_header_chunk_checker.sv =====
// PNG header checker: takes one file byte per clock on the push side while
// the queue is not full, with no stall from the parser, and puts one verdict
// per file into a 4-entry result queue that the user drains with pop. full
// rises only when four verdicts are waiting; a verdict is queued on the
// transfer of its deciding byte and shows on the result ports at the head.
// The byte rate rests on the combinational CRC-32 byte step in the parser.
// Limits must be written through the cfg port only with no file in flight;
// the block does not enforce it. Depends on pngc_pkg, pngc_parser, pngc_fifo.

module png_header_chunk_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // verdict output
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_status,
    output logic [30:0] o_image_width,
    output logic [30:0] o_image_height,
    output logic [7:0]  o_color_kind,
    output logic [31:0] o_idat_length,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [30:0] i_cfg_wr_data
);

    logic              in_xfer;
    logic              out_xfer;
    logic              res_push;
    pngc_pkg::t_result res_data;
    pngc_pkg::t_result head;

    assign in_xfer  = push && !full;
    assign out_xfer = pop && !empty;

    // Front: parser
    pngc_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (in_xfer),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_push        (res_push),
        .o_result      (res_data)
    );

    // Back: verdict queue
    pngc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_push),
        .i_data  (res_data),
        .i_rd    (out_xfer),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    assign o_status       = head.status;
    assign o_image_width  = head.image_width;
    assign o_image_height = head.image_height;
    assign o_color_kind   = head.color_kind;
    assign o_idat_length  = head.idat_length;

endmodule

// ===== tb/sv/png_verdict_checker.sv =====
`timescale 1ns / 100ps
// Verdict checker for the PNG header checker: predicts one verdict per file from the
// transferred bytes and compares it with each popped result. Holds png_tb_pkg as well.
// Depends on pngc_pkg for the result record, phase and status codes.

package png_tb_pkg;

    // File signature, chunk tags, big-endian byte order
    localparam logic [63:0] PNG_SIG  = 64'h8950_4E47_0D0A_1A0A;
    localparam logic [31:0] IHDR_TAG = 32'h4948_4452;
    localparam logic [31:0] IDAT_TAG = 32'h4944_4154;

    // Reflected CRC-32, folded in one data bit at a time
    function automatic logic [31:0] crc32_next(input logic [31:0] acc, input logic [7:0] b);
        logic fb;
        for (int k = 0; k < 8; k++) begin
            fb  = acc[0] ^ b[k];
            acc = acc >> 1;
            if (fb) acc = acc ^ 32'hEDB8_8320;
        end
        return acc;
    endfunction

endpackage

module png_verdict_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [3:0]  i_status,
    input  logic [30:0] i_image_width,
    input  logic [30:0] i_image_height,
    input  logic [7:0]  i_color_kind,
    input  logic [31:0] i_idat_length,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [30:0] i_cfg_wr_data,
    output int          o_fail_count,
    output int          o_pending
);
    import pngc_pkg::*;
    import png_tb_pkg::*;

    // Parser copy
    t_phase      ph;
    logic [31:0] cnt;
    logic [31:0] chunk_len;
    logic [31:0] crc_acc;
    logic [31:0] crc_rx;
    logic [31:0] w_seen;
    logic [31:0] h_seen;
    logic [39:0] hdr;       // depth, colour, compression, filter, interlace
    logic        name_ok;
    logic        done;
    logic [30:0] lim_w;
    logic [30:0] lim_h;

    t_result     verdict_q[$];
    int          fails = 0;

    task automatic clear_parse();
        ph        = PH_SIG;
        cnt       = '0;
        chunk_len = '0;
        crc_acc   = '1;
        crc_rx    = '0;
        w_seen    = '0;
        h_seen    = '0;
        hdr       = '0;
        name_ok   = 1'b1;
        done      = 1'b0;
    endtask

    // Verdict record with the fields known in the current phase
    function automatic t_result make_verdict(input t_status code);
        t_result r;
        logic    parsed;
        parsed         = (ph >= PH_IHDR_CRC) && (ph <= PH_IDAT_CRC);
        r.status       = code;
        r.image_width  = parsed ? w_seen[30:0] : '0;
        r.image_height = parsed ? h_seen[30:0] : '0;
        r.color_kind   = parsed ? hdr[31:24] : '0;
        r.idat_length  = (ph == PH_IDAT_DATA || ph == PH_IDAT_CRC) ? chunk_len : '0;
        return r;
    endfunction

    // Advance the parser by one transferred byte; queue any verdict it yields
    task automatic parse_byte(input logic [7:0] b, input logic fin);
        t_status code;
        logic    hit;
        int      idx;
        hit  = 1'b0;
        code = ST_TRUNCATED;
        if (done) begin
            // bytes after a verdict are dropped until the file ends
            if (fin) clear_parse();
        end else begin
            case (ph)
                PH_SIG: begin
                    idx = 7 - int'(cnt[2:0]);
                    if (b != PNG_SIG[idx*8 +: 8]) name_ok = 1'b0;
                    cnt++;
                    if (cnt == 32'd8) begin
                        if (!name_ok) begin
                            code = ST_SIGNATURE;
                            hit  = 1'b1;
                        end else begin
                            ph  = PH_IHDR_LEN;
                            cnt = '0;
                        end
                    end
                end
                PH_IHDR_LEN, PH_CH_LEN: begin
                    chunk_len = {chunk_len[23:0], b};
                    cnt++;
                    if (cnt == 32'd4) begin
                        ph      = (ph == PH_IHDR_LEN) ? PH_IHDR_TYPE : PH_CH_TYPE;
                        cnt     = '0;
                        crc_acc = '1;
                        name_ok = 1'b1;
                    end
                end
                PH_IHDR_TYPE: begin
                    crc_acc = crc32_next(crc_acc, b);
                    idx = 3 - int'(cnt[1:0]);
                    if (b != IHDR_TAG[idx*8 +: 8]) name_ok = 1'b0;
                    cnt++;
                    if (cnt == 32'd4) begin
                        // a bad tag wins over a bad length
                        if (!name_ok) begin
                            code = ST_IHDR_TYPE;
                            hit  = 1'b1;
                        end else if (chunk_len != 32'd13) begin
                            code = ST_IHDR_LEN;
                            hit  = 1'b1;
                        end else begin
                            ph  = PH_IHDR_DATA;
                            cnt = '0;
                        end
                    end
                end
                PH_IHDR_DATA: begin
                    crc_acc = crc32_next(crc_acc, b);
                    if (cnt < 32'd4)      w_seen = {w_seen[23:0], b};
                    else if (cnt < 32'd8) h_seen = {h_seen[23:0], b};
                    else                  hdr    = {hdr[31:0], b};
                    cnt++;
                    if (cnt == 32'd13) begin
                        ph     = PH_IHDR_CRC;
                        cnt    = '0;
                        crc_rx = '0;
                    end
                end
                PH_IHDR_CRC: begin
                    crc_rx = {crc_rx[23:0], b};
                    cnt++;
                    if (cnt == 32'd4) begin
                        // fault priority: crc, size, depth, compression, filter, interlace, colour type
                        hit = 1'b1;
                        if (~crc_acc != crc_rx) begin
                            code = ST_IHDR_CRC;
                        end else if (w_seen == 0 || h_seen == 0 ||
                                     w_seen > {1'b0, lim_w} || h_seen > {1'b0, lim_h}) begin
                            code = ST_SIZE;
                        end else if (hdr[39:32] != 8'd8) begin
                            code = ST_DEPTH;
                        end else if (hdr[23:16] != 8'd0) begin
                            code = ST_COMPRESSION;
                        end else if (hdr[15:8] != 8'd0) begin
                            code = ST_FILTER;
                        end else if (hdr[7:0] != 8'd0) begin
                            code = ST_INTERLACE;
                        end else if (hdr[31:24] == 8'd2) begin
                            code = ST_RGB_OK;
                        end else if (hdr[31:24] == 8'd6) begin
                            // RGBA goes on to look for IDAT
                            hit = 1'b0;
                            ph  = PH_CH_LEN;
                            cnt = '0;
                        end else begin
                            code = ST_COLOR_TYPE;
                        end
                    end
                end
                PH_CH_TYPE: begin
                    crc_acc = crc32_next(crc_acc, b);
                    idx = 3 - int'(cnt[1:0]);
                    if (b != IDAT_TAG[idx*8 +: 8]) name_ok = 1'b0;
                    cnt++;
                    if (cnt == 32'd4) begin
                        cnt    = '0;
                        crc_rx = '0;
                        if (name_ok) ph = (chunk_len == 0) ? PH_IDAT_CRC : PH_IDAT_DATA;
                        else         ph = (chunk_len == 0) ? PH_SKIP_CRC : PH_SKIP_DATA;
                    end
                end
                PH_SKIP_DATA: begin
                    cnt++;
                    if (cnt == chunk_len) begin
                        ph  = PH_SKIP_CRC;
                        cnt = '0;
                    end
                end
                PH_SKIP_CRC: begin
                    cnt++;
                    if (cnt == 32'd4) begin
                        ph        = PH_CH_LEN;
                        cnt       = '0;
                        chunk_len = '0;
                    end
                end
                PH_IDAT_DATA: begin
                    crc_acc = crc32_next(crc_acc, b);
                    cnt++;
                    if (cnt == chunk_len) begin
                        ph  = PH_IDAT_CRC;
                        cnt = '0;
                    end
                end
                PH_IDAT_CRC: begin
                    crc_rx = {crc_rx[23:0], b};
                    cnt++;
                    if (cnt == 32'd4) begin
                        code = (~crc_acc == crc_rx) ? ST_RGBA_OK : ST_IDAT_CRC;
                        hit  = 1'b1;
                    end
                end
                default: ;
            endcase

            if (hit) begin
                verdict_q.push_back(make_verdict(code));
                done = 1'b1;
            end else if (fin) begin
                verdict_q.push_back(make_verdict(ST_TRUNCATED));
            end
            if (fin) clear_parse();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
            fails++;
        end
    endtask

    task automatic check_result();
        t_result want;
        if (verdict_q.size() == 0) begin
            $display("%0t: unexpected verdict: expected none, got status %0d",
                     $time, i_status);
            fails++;
        end else begin
            want = verdict_q.pop_front();
            check_field("status", 32'(want.status), 32'(i_status));
            check_field("image_width", 32'(want.image_width), 32'(i_image_width));
            check_field("image_height", 32'(want.image_height), 32'(i_image_height));
            check_field("color_kind", 32'(want.color_kind), 32'(i_color_kind));
            check_field("idat_length", want.idat_length, i_idat_length);
        end
    endtask

    // Result transfer is checked before the byte of the same edge is predicted:
    // a verdict never shows in the cycle of its own byte
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse();
            lim_w = MAX_DIM_RESET;
            lim_h = MAX_DIM_RESET;
            verdict_q.delete();
        end else begin
            if (i_pop && !i_empty) check_result();
            if (i_push && !i_full) parse_byte(i_data_byte, i_last_byte);
            if (i_cfg_wr_en) begin
                if (i_cfg_index == CFG_MAX_WIDTH) lim_w = i_cfg_wr_data;
                else                              lim_h = i_cfg_wr_data;
            end
        end
        o_pending    = verdict_q.size();
        o_fail_count = fails;
    end

endmodule

// ===== tb/sv/png_header_chunk_checker_tb.sv =====
`timescale 1ns / 100ps
// Testbench top: builds PNG byte streams (good, faulty, cut short, noise), drives the
// byte and verdict queues with random gaps and sets the size limits between phases.
// Depends on pngc_pkg, png_tb_pkg, png_verdict_checker and png_header_chunk_checker.

module png_header_chunk_checker_tb;
    import pngc_pkg::*;
    import png_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASE_BYTES    = 160;
    localparam int PHASE_FILES    = 3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [3:0]  o_status;
    logic [30:0] o_image_width;
    logic [30:0] o_image_height;
    logic [7:0]  o_color_kind;
    logic [31:0] o_idat_length;
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [30:0] i_cfg_wr_data = '0;

    int          fail_count;
    int          pending;
    logic        in_xfer = 1'b0;
    logic        out_xfer = 1'b0;
    int          idle_cycles = 0;
    logic        tx_burst = 1'b0;
    logic        rx_burst = 1'b0;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;
    int          bytes_sent = 0;
    int          files_sent = 0;
    logic [30:0] lim_w = MAX_DIM_RESET;
    logic [30:0] lim_h = MAX_DIM_RESET;
    logic [7:0]  file_q[$];
    logic [7:0]  chunk_data[$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    png_header_chunk_checker dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .empty          (empty),
        .pop            (pop),
        .o_status       (o_status),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height),
        .o_color_kind   (o_color_kind),
        .o_idat_length  (o_idat_length),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    png_verdict_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_status       (o_status),
        .i_image_width  (o_image_width),
        .i_image_height (o_image_height),
        .i_color_kind   (o_color_kind),
        .i_idat_length  (o_idat_length),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Transfer flags of the last edge, read by the drivers at the falling edge
    always @(posedge i_clk) begin
        in_xfer  <= push && !full;
        out_xfer <= pop && !empty;
    end

    // Watchdog: too many cycles without any transfer
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stream assembly
    task automatic push_word(input logic [31:0] v);
        for (int k = 3; k >= 0; k--) file_q.push_back(v[k*8 +: 8]);
    endtask

    // Chunk from chunk_data; length field given apart so it can lie
    task automatic add_chunk(input logic [31:0] len, input logic [31:0] tag,
                             input logic bad_crc);
        logic [31:0] acc;
        acc = '1;
        push_word(len);
        push_word(tag);
        for (int k = 3; k >= 0; k--) acc = crc32_next(acc, tag[k*8 +: 8]);
        foreach (chunk_data[k]) begin
            acc = crc32_next(acc, chunk_data[k]);
            file_q.push_back(chunk_data[k]);
        end
        acc = ~acc;
        if (bad_crc) acc = acc ^ ($urandom | 32'd1);
        push_word(acc);
    endtask

    task automatic add_sig(input int bad_pos);
        logic [7:0] b;
        for (int k = 0; k < 8; k++) begin
            b = PNG_SIG[(7 - k)*8 +: 8];
            if (k == bad_pos) b = b ^ 8'($urandom_range(1, 255));
            file_q.push_back(b);
        end
    endtask

    task automatic add_ihdr(input logic [31:0] len, input logic [31:0] tag,
                            input logic [31:0] w, input logic [31:0] h,
                            input logic [7:0] depth, input logic [7:0] colour,
                            input logic [23:0] cfi, input logic bad_crc);
        chunk_data.delete();
        for (int k = 3; k >= 0; k--) chunk_data.push_back(w[k*8 +: 8]);
        for (int k = 3; k >= 0; k--) chunk_data.push_back(h[k*8 +: 8]);
        chunk_data.push_back(depth);
        chunk_data.push_back(colour);
        for (int k = 2; k >= 0; k--) chunk_data.push_back(cfi[k*8 +: 8]);
        add_chunk(len, tag, bad_crc);
    endtask

    task automatic add_data_chunk(input logic [31:0] tag);
        chunk_data.delete();
        repeat ($urandom_range(0, 6)) chunk_data.push_back(8'($urandom_range(0, 255)));
        add_chunk(32'(chunk_data.size()), tag, $urandom_range(0, 7) == 0);
    endtask

    // Width or height around the current limit and the 31-bit edge
    function automatic logic [31:0] pick_dim(input logic [30:0] lim);
        logic [31:0] cap;
        logic [31:0] v;
        cap = (lim > 31'd64) ? 32'd64 : {1'b0, lim};
        case ($urandom_range(0, 15))
            0:       v = 32'd0;
            1:       v = 32'd1;
            2:       v = {1'b0, lim};
            3:       v = {1'b0, lim} + 32'd1;
            4:       v = 32'h7FFF_FFFF;
            5:       v = 32'h8000_0000;
            6:       v = 32'hFFFF_FFFF;
            7:       v = $urandom;
            default: v = $urandom_range(1, cap);
        endcase
        return v;
    endfunction

    // Mostly well-formed file with random content and occasional header faults
    task automatic build_png();
        logic [31:0] len;
        logic [31:0] tag;
        logic [7:0]  depth;
        logic [7:0]  colour;
        logic [23:0] cfi;
        int          sel;
        file_q.delete();
        add_sig(($urandom_range(0, 15) == 0) ? int'($urandom_range(0, 7)) : -1);
        len = ($urandom_range(0, 15) == 0) ? $urandom : 32'd13;
        tag = IHDR_TAG;
        if ($urandom_range(0, 15) == 0) begin
            sel = $urandom_range(0, 3);
            tag[sel*8 +: 8] = tag[sel*8 +: 8] ^ 8'($urandom_range(1, 255));
        end
        depth = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : BIT_DEPTH_8;
        sel = $urandom_range(0, 9);
        if (sel < 4)      colour = COLOR_RGB;
        else if (sel < 8) colour = COLOR_RGBA;
        else              colour = 8'($urandom_range(0, 255));
        cfi = '0;
        for (int k = 0; k < 3; k++) begin
            if ($urandom_range(0, 11) == 0) cfi[k*8 +: 8] = 8'($urandom_range(0, 255));
        end
        add_ihdr(len, tag, pick_dim(lim_w), pick_dim(lim_h), depth, colour, cfi,
                 $urandom_range(0, 11) == 0);
        // RGB files sometimes end right at their verdict
        if (colour != COLOR_RGB || $urandom_range(0, 2) != 0) begin
            repeat ($urandom_range(0, 2)) begin
                if ($urandom_range(0, 2) == 0) tag = IDAT_TAG ^ (32'd1 << $urandom_range(0, 31));
                else                           tag = $urandom;
                add_data_chunk(tag);
            end
            add_data_chunk(IDAT_TAG);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push        = 1'b1;
        i_data_byte = b;
        i_last_byte = fin;
        do @(negedge i_clk); while (!in_xfer);
        bytes_sent++;
    endtask

    // Send file_q with last_byte on its final byte; optionally damage it first
    task automatic send_png(input logic mutate);
        int n;
        int mode;
        int pos;
        n = file_q.size();
        if (mutate) begin
            mode = $urandom_range(0, 9);
            if (mode == 0) begin
                pos = $urandom_range(0, n - 1);
                file_q[pos] = file_q[pos] ^ 8'($urandom_range(1, 255));
            end else if (mode == 1) begin
                n = $urandom_range(1, n);
            end else if (mode == 2) begin
                file_q.delete();
                n = $urandom_range(1, 12);
                repeat (n) file_q.push_back(8'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 3) == 0) tx_burst = !tx_burst;
        for (int k = 0; k < n; k++) send_byte(file_q[k], k == n - 1);
        files_sent++;
    endtask

    task automatic wait_idle();
        push = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_limits(input logic [30:0] w, input logic [30:0] h);
        i_cfg_wr_en   = 1'b1;
        i_cfg_index   = CFG_MAX_WIDTH;
        i_cfg_wr_data = w;
        @(negedge i_clk);
        i_cfg_index   = CFG_MAX_HEIGHT;
        i_cfg_wr_data = h;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        lim_w = w;
        lim_h = h;
    endtask

    task automatic run_phase(input logic [30:0] w, input logic [30:0] h);
        int b0;
        int f0;
        wait_idle();
        set_limits(w, h);
        b0 = bytes_sent;
        f0 = files_sent;
        while (bytes_sent - b0 < PHASE_BYTES || files_sent - f0 < PHASE_FILES) begin
            build_png();
            send_png(1'b1);
        end
    endtask

    // Verdict side: random pop gaps, one long hold-off on request
    initial begin
        int gap;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = rx_burst ? 0 : $urandom_range(0, 3);
            if (hold_req && !hold_done) begin
                gap       = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (gap > 0) begin
                pop = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            pop = 1'b1;
            do @(negedge i_clk); while (!out_xfer);
            if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
        end
    end

    // Byte side and verdict
    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // one byte only: truncated inside the signature
        file_q.delete();
        file_q.push_back(8'h89);
        send_png(1'b0);

        // bad last signature byte, then bytes past the verdict
        file_q.delete();
        add_sig(7);
        file_q.push_back(8'h00);
        file_q.push_back(8'hFF);
        send_png(1'b0);

        // smallest RGB image, verdict on the final byte
        file_q.delete();
        add_sig(-1);
        add_ihdr(32'd13, IHDR_TAG, 32'd1, 32'd1, BIT_DEPTH_8, COLOR_RGB, 24'd0, 1'b0);
        send_png(1'b0);

        // bad tag and bad length together
        file_q.delete();
        add_sig(-1);
        push_word(32'd14);
        push_word(IHDR_TAG ^ 32'h0000_0001);
        send_png(1'b0);

        // RGBA at the limit, empty ancillary chunk and empty IDAT
        file_q.delete();
        add_sig(-1);
        add_ihdr(32'd13, IHDR_TAG, {1'b0, MAX_DIM_RESET}, {1'b0, MAX_DIM_RESET},
                 BIT_DEPTH_8, COLOR_RGBA, 24'd0, 1'b0);
        chunk_data.delete();
        add_chunk(32'd0, 32'h7445_5874, 1'b0);
        add_chunk(32'd0, IDAT_TAG, 1'b0);
        send_png(1'b0);

        run_phase(MAX_DIM_RESET, MAX_DIM_RESET);
        run_phase(31'd1, 31'd1);

        // hold off the verdict side while short files keep arriving
        hold_req = 1'b1;
        repeat (12) begin
            file_q.delete();
            file_q.push_back(8'($urandom_range(0, 255)));
            send_png(1'b0);
        end

        run_phase(31'h7FFF_FFFF, 31'h7FFF_FFFF);
        run_phase(31'($urandom), 31'($urandom));
        run_phase(31'($urandom_range(1, 64)), 31'($urandom_range(1, 64)));

        wait_idle();
        if (fail_count == 0) $display("SUCCESS");
        else                 $display("FAILURE");
        $finish;
    end

endmodule
